// ===== sv/mcd_pkg.sv =====
// Shared types, constants and the letter lookup table for the Morse decoder.
package mcd_pkg;

  // Input byte codes
  localparam logic [7:0] AsciiDot   = 8'd46;
  localparam logic [7:0] AsciiDash  = 8'd45;
  localparam logic [7:0] AsciiSpace = 8'd32;

  // Output character codes
  localparam logic [6:0] CharSpace   = 7'd32;
  localparam logic [6:0] CharUnknown = 7'd0;

  // Result queue depth (power of two, at least two)
  localparam int unsigned FifoDepth = 4;

  typedef struct packed {
    logic [6:0] ch;
    logic       has_char;
    logic       eom;
    logic       last;
  } result_t;

  // Look up a letter: len symbols, symbol i at pat[i], 1 = dash.
  function automatic logic [6:0] decode_letter(input logic [3:0] len, input logic [7:0] pat);
    logic [6:0] ch;
    ch = CharUnknown;
    case (len)
      4'd1: begin
        case (pat[0])
          1'b0:    ch = 7'd69;  // E
          1'b1:    ch = 7'd84;  // T
          default: ch = CharUnknown;
        endcase
      end
      4'd2: begin
        case (pat[1:0])
          2'b10:   ch = 7'd65;  // A
          2'b00:   ch = 7'd73;  // I
          2'b11:   ch = 7'd77;  // M
          2'b01:   ch = 7'd78;  // N
          default: ch = CharUnknown;
        endcase
      end
      4'd3: begin
        case (pat[2:0])
          3'b001:  ch = 7'd68;  // D
          3'b011:  ch = 7'd71;  // G
          3'b101:  ch = 7'd75;  // K
          3'b111:  ch = 7'd79;  // O
          3'b010:  ch = 7'd82;  // R
          3'b000:  ch = 7'd83;  // S
          3'b100:  ch = 7'd85;  // U
          3'b110:  ch = 7'd87;  // W
          default: ch = CharUnknown;
        endcase
      end
      4'd4: begin
        case (pat[3:0])
          4'b0001: ch = 7'd66;  // B
          4'b0101: ch = 7'd67;  // C
          4'b0100: ch = 7'd70;  // F
          4'b0000: ch = 7'd72;  // H
          4'b1110: ch = 7'd74;  // J
          4'b0010: ch = 7'd76;  // L
          4'b0110: ch = 7'd80;  // P
          4'b1011: ch = 7'd81;  // Q
          4'b1000: ch = 7'd86;  // V
          4'b1001: ch = 7'd88;  // X
          4'b1101: ch = 7'd89;  // Y
          4'b0011: ch = 7'd90;  // Z
          default: ch = CharUnknown;
        endcase
      end
      4'd5: begin
        case (pat[4:0])
          5'b11111: ch = 7'd48;  // 0
          5'b11110: ch = 7'd49;  // 1
          5'b11100: ch = 7'd50;  // 2
          5'b11000: ch = 7'd51;  // 3
          5'b10000: ch = 7'd52;  // 4
          5'b00000: ch = 7'd53;  // 5
          5'b00001: ch = 7'd54;  // 6
          5'b00011: ch = 7'd55;  // 7
          5'b00111: ch = 7'd56;  // 8
          5'b01111: ch = 7'd57;  // 9
          5'b01001: ch = 7'd47;  // slash
          5'b01101: ch = 7'd40;  // open paren
          5'b00010: ch = 7'd38;  // ampersand
          5'b10001: ch = 7'd61;  // equals
          5'b01010: ch = 7'd43;  // plus
          default:  ch = CharUnknown;
        endcase
      end
      4'd6: begin
        case (pat[5:0])
          6'b101010: ch = 7'd46;  // period
          6'b110011: ch = 7'd44;  // comma
          6'b001100: ch = 7'd63;  // question mark
          6'b011110: ch = 7'd39;  // apostrophe
          6'b110101: ch = 7'd33;  // exclamation
          6'b101101: ch = 7'd41;  // close paren
          6'b000111: ch = 7'd58;  // colon
          6'b010101: ch = 7'd59;  // semicolon
          6'b100001: ch = 7'd45;  // hyphen
          6'b101100: ch = 7'd95;  // underscore
          6'b010010: ch = 7'd34;  // double quote
          6'b010110: ch = 7'd64;  // at sign
          default:   ch = CharUnknown;
        endcase
      end
      default: ch = CharUnknown;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/mcd_state_mem.sv =====
// Single-entry letter state memory with a registered read and write forwarding.
module mcd_state_mem #(
  parameter int unsigned Width = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [1];
  logic [Width-1:0] rd_q;
  logic [Width-1:0] fwd_data_q;
  logic             fwd_vld_q;
  logic             written_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[0] <= wr_data_i;
    end
    rd_q       <= mem_q[0];
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      written_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en_i;
      rd_vld_q  <= written_q;
      if (wr_en_i) begin
        written_q <= 1'b1;
      end
    end
  end

  // Last write wins; an entry never written reads as the reset state.
  assign rd_data_o = fwd_vld_q ? fwd_data_q :
                     rd_vld_q  ? rd_q       : '0;

endmodule

// ===== sv/mcd_update.sv =====
// Next-state and result logic for one input byte.
module mcd_update import mcd_pkg::*; #(
  parameter int unsigned MaxSymbols = 6
) (
  input  logic [MaxSymbols+$clog2(MaxSymbols+2):0] state_i,
  input  logic [7:0]                               symbol_char_i,
  input  logic                                     end_of_line_i,
  output logic [MaxSymbols+$clog2(MaxSymbols+2):0] state_o,
  output result_t                                  res0_o,
  output result_t                                  res1_o,
  output logic [1:0]                               num_o
);

  localparam int unsigned IdxW = $clog2(MaxSymbols);
  localparam int unsigned CntW = $clog2(MaxSymbols + 2);

  logic [MaxSymbols-1:0] pat, pat1;
  logic [CntW-1:0]       cnt, cnt1;
  logic                  gap, gap1;
  logic                  is_dash, is_morse, is_gap;
  logic                  flush_old, flush_sp;
  logic [6:0]            old_ch, new_ch;
  result_t               res [2];
  logic [1:0]            n;

  assign {gap, cnt, pat} = state_i;
  assign is_dash  = (symbol_char_i == AsciiDash);
  assign is_morse = is_dash || (symbol_char_i == AsciiDot);
  assign is_gap   = (symbol_char_i == AsciiSpace);

  assign old_ch = (cnt == '0 || cnt > CntW'(MaxSymbols)) ? CharUnknown :
                  decode_letter(4'(cnt), 8'(pat));
  assign new_ch = (cnt1 == '0 || cnt1 > CntW'(MaxSymbols)) ? CharUnknown :
                  decode_letter(4'(cnt1), 8'(pat1));

  // Resolve a pending gap or mark a new one, then append a symbol.
  always_comb begin
    gap1      = gap;
    cnt1      = cnt;
    pat1      = pat;
    flush_old = 1'b0;
    flush_sp  = 1'b0;
    if (gap) begin
      gap1      = 1'b0;
      flush_old = (cnt != '0);
      flush_sp  = (cnt != '0) && is_gap;
      cnt1      = '0;
      pat1      = '0;
    end else if (is_gap) begin
      gap1 = 1'b1;
    end
    if (is_morse) begin
      if (cnt1 < CntW'(MaxSymbols)) begin
        if (is_dash) begin
          pat1[cnt1[IdxW-1:0]] = 1'b1;
        end
        cnt1 = cnt1 + CntW'(1);
      end else begin
        cnt1 = CntW'(MaxSymbols + 1);
      end
    end
  end

  // Collect up to two results; end of line flushes and tags the final one.
  always_comb begin
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    state_o = {gap1, cnt1, pat1};
    if (flush_old) begin
      res[n[0]].ch       = old_ch;
      res[n[0]].has_char = 1'b1;
      n = n + 2'd1;
    end
    if (flush_sp) begin
      res[n[0]].ch       = CharSpace;
      res[n[0]].has_char = 1'b1;
      n = n + 2'd1;
    end
    if (end_of_line_i) begin
      if (cnt1 != '0) begin
        res[n[0]].ch       = new_ch;
        res[n[0]].has_char = 1'b1;
        n = n + 2'd1;
        if (gap1) begin
          res[n[0]].ch       = CharSpace;
          res[n[0]].has_char = 1'b1;
          n = n + 2'd1;
        end
      end
      if (n == 2'd0) begin
        n = 2'd1;
      end
      res[n[1]].eom = 1'b1;
      state_o = '0;
    end
    if (n != 2'd0) begin
      res[n[1]].last = 1'b1;
    end
  end

  assign res0_o = res[0];
  assign res1_o = res[1];
  assign num_o  = n;

endmodule

// ===== sv/mcd_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a beat.
module mcd_out_fifo import mcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  result_t         slot_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign pop       = valid_o && ready_i;
  assign valid_o   = (cnt_q != '0);
  assign space_o   = (cnt_q <= CntW'(FifoDepth - 2));
  assign head_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      slot_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      slot_q[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_num_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_num_i) - CntW'(pop);
    end
  end

endmodule

// ===== sv/morse_code_decoder.sv =====
// Top level of the Morse code decoder: byte stream in, decoded characters out.
//
// Input channel (s_axis): one ASCII byte a beat in tdata. A dot is '.', a dash
// is '-', a space is a gap; every other byte is dropped, except that it closes
// a letter left open by a single gap. tlast marks the final byte of a line.
// Output channel (m_axis): one result a beat. tdata holds the character (0 for
// an unknown or overlong pattern, 32 for a word space), tuser[0] says whether
// the character is real (0 only on the bare end marker of an empty line),
// tuser[1] flags the final result of a line, tlast the last result of a byte.
// Each byte yields zero, one or two results.
// Results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle while the result queue has room. The letter
// state lives in a one-entry memory read every cycle, with the last write
// forwarded around its registered read. Bytes that yield two results are
// limited by the output side to one result per cycle.
// Reset: the letter state reads as empty and the result queue is emptied.
// Stall: results wait in a four-entry queue; tready drops while fewer than
// two entries are free, and rises again as soon as the receiver drains them.
module morse_code_decoder import mcd_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol_char
  input  logic       s_axis_tlast,   // end_of_line
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] character, [7] zero
  output logic [1:0] m_axis_tuser,   // [0] has_char, [1] end_of_message
  output logic       m_axis_tlast    // last result of the input beat
);

  // pattern bits, symbol count (one code above the limit marks overlong), gap flag
  localparam int unsigned CntW   = $clog2(MAX_SYMBOLS + 2);
  localparam int unsigned StateW = MAX_SYMBOLS + CntW + 1;

  logic [StateW-1:0] state_cur, state_nxt;
  logic              in_acc;
  logic              fifo_space;
  result_t           res0, res1, head;
  logic [1:0]        res_num;

  assign s_axis_tready = fifo_space;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Hold the letter state; write it back on every accepted beat.
  mcd_state_mem #(
    .Width(StateW)
  ) u_state_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_acc),
    .wr_data_i(state_nxt),
    .rd_data_o(state_cur)
  );

  mcd_update #(
    .MaxSymbols(MAX_SYMBOLS)
  ) u_update (
    .state_i      (state_cur),
    .symbol_char_i(s_axis_tdata),
    .end_of_line_i(s_axis_tlast),
    .state_o      (state_nxt),
    .res0_o       (res0),
    .res1_o       (res1),
    .num_o        (res_num)
  );

  // Queue only what an accepted beat produced.
  mcd_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_num_i(in_acc ? res_num : 2'd0),
    .push0_i   (res0),
    .push1_i   (res1),
    .space_o   (fifo_space),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .head_o    (head)
  );

  assign m_axis_tdata = {1'b0, head.ch};
  assign m_axis_tuser = {head.eom, head.has_char};
  assign m_axis_tlast = head.last;

endmodule

// ===== sv/mcd_checker.sv =====
// Port-level checks for the Morse decoder, bound to the top level.
module mcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // The end of a line is always the last result of its byte.
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("end_of_message without tlast");

  // A bare marker carries no character and closes both the byte and the line.
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata == 8'd0 && m_axis_tuser[1] && m_axis_tlast)
    else $error("malformed bare end marker");

  // Characters are 7-bit; the pad bit stays clear.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[7])
    else $error("pad bit set in tdata");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

endmodule

bind morse_code_decoder mcd_checker u_mcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
